>>> rtl/lie_pkg.sv
package lie_pkg;

  localparam int ENERGY_W = 15;
  localparam int SPIN_W   = 1;
  localparam int SIDE_W   = 7;
  localparam int MIN_SIDE = 3;
  localparam int E_MAX    = 16383;
  localparam int E_MIN    = -16384;

  localparam int BOND_LEFT = 0;
  localparam int BOND_UP   = 1;
  localparam int BOND_ROW  = 2;
  localparam int BOND_COL  = 3;
  localparam int N_BONDS   = 4;

  typedef logic [N_BONDS-1:0] bond_mask_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_ADD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic differ;
  } acc_ctrl_t;

endpackage

>>> rtl/lie_if.sv
interface lie_spin_if;
  import lie_pkg::*;
  logic              valid;
  logic              ready;
  logic [SPIN_W-1:0] spin_up;

  modport source (output valid, output spin_up, input ready);
  modport sink   (input valid, input spin_up, output ready);
endinterface

interface lie_energy_if;
  import lie_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ENERGY_W-1:0] total_energy;

  modport source (output valid, output total_energy, input ready);
  modport sink   (input valid, input total_energy, output ready);
endinterface

>>> rtl/lie_spin_ram.sv
module lie_spin_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lie_energy_acc.sv
module lie_energy_acc #(
  parameter int ACC_W = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lie_pkg::acc_ctrl_t                  ctrl,
  output logic signed [lie_pkg::ENERGY_W-1:0] energy
);
  import lie_pkg::*;

  localparam logic signed [ACC_W-1:0] HI = ACC_W'(E_MAX);
  localparam logic signed [ACC_W-1:0] LO = ACC_W'(E_MIN);
  localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;

  always_comb begin
    acc_next = acc;
    priority if (ctrl.clear) begin
      acc_next = '0;
    end else if (ctrl.add) begin
      acc_next = ctrl.differ ? acc + ONE : acc - ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  always_comb begin
    priority if (acc > HI) begin
      energy = ENERGY_W'(HI);
    end else if (acc < LO) begin
      energy = ENERGY_W'(LO);
    end else begin
      energy = ENERGY_W'(acc);
    end
  end

endmodule

>>> rtl/lattice_ising_total_energy_core.sv
// channel  | dir | payload                | transfer
// spins    | in  | spin_up [0:0]          | valid & ready
// energy   | out | total_energy [14:0] s  | valid & ready
// cfg      | in  | cfg_wdata [6:0]        | cfg_we
// One spin walks the b = 0..4 bonds it closes one by one, paced by the
// single read port of the spin store: one neighbour read per bond.
// The energy of a lattice appears in the output register after its last spin.
// A full output register stalls only the last spin of the next lattice.
// Reset (rst, synchronous) clears counters, energy and sets side to 64.
module lattice_ising_total_energy_core #(
  parameter int SIDE = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  lie_spin_if.sink                     spins,
  lie_energy_if.source                 energy,
  input  logic                         cfg_we,
  input  logic [lie_pkg::SIDE_W-1:0]   cfg_wdata
);
  import lie_pkg::*;

  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SIDE);
  localparam int EW    = $clog2(2 * SIDE * SIDE + 1) + 1;
  localparam int ACC_W = (EW > 16) ? EW : 16;
  localparam logic [8:0] SIDE_MAX = 9'(SIDE);
  localparam logic [8:0] SIDE_MIN = 9'(MIN_SIDE);

  state_t state;
  state_t state_next;

  logic [SIDE_W-1:0] side;
  logic [7:0]        l_eff;
  logic [CW-1:0]     row;
  logic [CW-1:0]     col;
  logic [AW-1:0]     pos;
  logic              spin;
  bond_mask_t        pend;
  bond_mask_t        need;

  logic              col_last;
  logic              row_last;
  logic              accept;
  logic              out_free;
  logic              last_site;
  logic              advance;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              rd_data;
  logic              pick_bit;
  bond_mask_t        pend_next;

  acc_ctrl_t                  acc_ctrl;
  logic signed [ENERGY_W-1:0] acc_energy;

  always_comb begin
    priority if (9'(side) < SIDE_MIN) begin
      l_eff = 8'(SIDE_MIN);
    end else if (9'(side) > SIDE_MAX) begin
      l_eff = 8'(SIDE_MAX);
    end else begin
      l_eff = 8'(side);
    end
  end

  assign col_last  = (col == CW'(l_eff - 8'd1));
  assign row_last  = (row == CW'(l_eff - 8'd1));
  assign accept    = spins.valid && spins.ready;
  assign out_free  = !energy.valid || energy.ready;
  assign last_site = col_last && row_last;
  assign advance   = (state == S_FINISH) && (!last_site || out_free);

  always_comb begin
    need            = '0;
    need[BOND_LEFT] = (col != '0);
    need[BOND_UP]   = (row != '0);
    need[BOND_ROW]  = col_last;
    need[BOND_COL]  = row_last;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_PICK;
      S_PICK:   state_next = (pend == '0) ? S_FINISH : S_ADD;
      S_ADD:    state_next = S_PICK;
      S_FINISH: if (advance) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    spins.ready     = 1'b0;
    rd_en           = 1'b0;
    acc_ctrl.clear  = cfg_we;
    acc_ctrl.add    = 1'b0;
    acc_ctrl.differ = spin ^ rd_data;
    unique case (state)
      S_IDLE:   spins.ready = 1'b1;
      S_PICK:   rd_en = (pend != '0);
      S_ADD:    acc_ctrl.add = 1'b1;
      S_FINISH: if (advance && last_site) acc_ctrl.clear = 1'b1;
      default:  ;
    endcase
  end

  // pick lowest pending bond, form its neighbour address
  always_comb begin
    pend_next = pend;
    pick_bit  = 1'b0;
    rd_addr   = pos - AW'(1);
    priority if (pend[BOND_LEFT]) begin
      rd_addr = pos - AW'(1);
      pend_next[BOND_LEFT] = 1'b0;
    end else if (pend[BOND_UP]) begin
      rd_addr = pos - AW'(l_eff);
      pend_next[BOND_UP] = 1'b0;
    end else if (pend[BOND_ROW]) begin
      rd_addr = pos - AW'(l_eff - 8'd1);
      pend_next[BOND_ROW] = 1'b0;
    end else if (pend[BOND_COL]) begin
      rd_addr = AW'(col);
      pend_next[BOND_COL] = 1'b0;
    end else begin
      pick_bit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= SIDE_W'(64);
      row   <= '0;
      col   <= '0;
      pos   <= '0;
      pend  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        side <= cfg_wdata;
        row  <= '0;
        col  <= '0;
        pos  <= '0;
      end else if (advance) begin
        if (last_site) begin
          row <= '0;
          col <= '0;
          pos <= '0;
        end else if (col_last) begin
          row <= row + CW'(1);
          col <= '0;
          pos <= pos + AW'(1);
        end else begin
          col <= col + CW'(1);
          pos <= pos + AW'(1);
        end
      end
      if (accept) begin
        pend <= need;
      end else if (state == S_PICK && !pick_bit) begin
        pend <= pend_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      spin <= spins.spin_up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy.valid <= 1'b0;
    end else if (advance && last_site) begin
      energy.valid <= 1'b1;
    end else if (energy.ready) begin
      energy.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_site) begin
      energy.total_energy <= acc_energy;
    end
  end

  lie_spin_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (pos),
    .wdata (spins.spin_up),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lie_energy_acc #(
    .ACC_W (ACC_W)
  ) u_acc (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (acc_ctrl),
    .energy (acc_energy)
  );

  a_accept_to_pick: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_PICK)
    else $error("transfer not followed by bond walk");

  a_pend_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && pend != '0) |=>
      $countones(pend) == $countones($past(pend)) - 1)
    else $error("bond mask did not drop one bond");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(energy.valid) |-> $past(state) == S_FINISH && $past(last_site))
    else $error("energy raised outside a lattice end");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (9'(row) < 9'(l_eff)) && (9'(col) < 9'(l_eff)))
    else $error("site position outside lattice");

endmodule
